// ===== rtl/acp_pkg.sv =====
// ----------------------------------------------------------------------------
// AT command line parser package
// Shared request types, character codes, result codes and register indexes.
// ----------------------------------------------------------------------------
package acp_pkg;

    // One input request: a received byte or a time check.
    typedef struct packed {
        logic        opcode;
        logic [7:0]  data_byte;
        logic [31:0] now_ms;
    } t_in_item;

    // One result request.
    typedef struct packed {
        logic [1:0] verdict;
        logic [1:0] command_kind;
        logic [7:0] name_length;
        logic [7:0] args_offset;
        logic [7:0] args_length;
    } t_out_item;

    // Input operations.
    localparam logic OP_BYTE  = 1'b0;
    localparam logic OP_CHECK = 1'b1;

    // Verdict codes.
    localparam logic [1:0] VERDICT_OK      = 2'd0;
    localparam logic [1:0] VERDICT_ERROR   = 2'd1;
    localparam logic [1:0] VERDICT_REQUEST = 2'd2;

    // Command kinds.
    localparam logic [1:0] KIND_EXEC  = 2'd0;
    localparam logic [1:0] KIND_QUERY = 2'd1;
    localparam logic [1:0] KIND_SETUP = 2'd2;

    // Configuration register indexes.
    localparam int unsigned CFG_INDEX_W = 2;
    localparam int unsigned CFG_DATA_W  = 16;
    localparam logic [CFG_INDEX_W-1:0] CFG_TIMEOUT = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_HANDLER = 2'd1;

    // Character codes.
    localparam logic [7:0] CH_A     = 8'h41;
    localparam logic [7:0] CH_T     = 8'h54;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_QUERY = 8'h3F;
    localparam logic [7:0] CH_EQ    = 8'h3D;
    localparam logic [7:0] CH_UNDER = 8'h5F;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_NUL   = 8'h00;

    // Progress of the incremental line classification, one-hot.
    typedef enum logic [10:0] {
        PH_A         = 11'b000_0000_0001, // expecting 'A'
        PH_T         = 11'b000_0000_0010, // expecting 'T'
        PH_PLUS      = 11'b000_0000_0100, // "AT" seen
        PH_NAME0     = 11'b000_0000_1000, // "AT+" seen, name empty
        PH_NAME      = 11'b000_0001_0000, // inside a non-empty name
        PH_QUERY     = 11'b000_0010_0000, // '?' after the name
        PH_QEND      = 11'b000_0100_0000, // '?' then a zero byte
        PH_ARGS      = 11'b000_1000_0000, // counting arguments after '='
        PH_EXEC      = 11'b001_0000_0000, // zero byte ended the name
        PH_SETUP_END = 11'b010_0000_0000, // zero byte ended the arguments
        PH_ERR       = 11'b100_0000_0000  // line is malformed
    } t_phase;

    // Letters, digits and underscore may form a command name.
    function automatic logic is_name_byte(input logic [7:0] b);
        return (b >= 8'h41 && b <= 8'h5A) || (b >= 8'h61 && b <= 8'h7A) ||
               (b >= 8'h30 && b <= 8'h39) || (b == CH_UNDER);
    endfunction

endpackage

// ===== rtl/acp_line_tracker.sv =====
// ----------------------------------------------------------------------------
// AT command line tracker
// Holds the line state and classifies the line byte by byte as it arrives.
// ----------------------------------------------------------------------------
module acp_line_tracker #(
    parameter int unsigned BUFFER_BYTES = 256
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  acp_pkg::t_in_item i_item,
    input  logic [15:0]       i_timeout_ms,
    input  logic              i_handler_present,
    output logic              o_res_valid,
    output acp_pkg::t_out_item o_res
);

    localparam int unsigned CW = $clog2(BUFFER_BYTES);
    localparam logic [CW-1:0] LINE_MAX = CW'(BUFFER_BYTES - 1);

    logic [CW-1:0]    r_count, n_count;
    logic             r_cr, n_cr;
    logic             r_too_long, n_too_long;
    logic [31:0]      r_last, n_last;
    acp_pkg::t_phase  r_phase, n_phase;
    logic [CW-1:0]    r_nc, n_nc;
    logic [CW-1:0]    r_alen, n_alen;
    logic [CW-1:0]    r_aoff, n_aoff;

    logic        partial;
    logic [31:0] elapsed;
    logic        expired;
    logic [7:0]  b;
    logic        do_append;

    function automatic logic [7:0] to8(input logic [CW-1:0] x);
        logic [CW+7:0] w;
        w = {8'd0, x};
        return w[7:0];
    endfunction

    assign partial = (r_count != '0) || r_cr || r_too_long;
    assign elapsed = i_item.now_ms - r_last;
    assign expired = (i_timeout_ms != 16'd0) && partial && (elapsed >= {16'd0, i_timeout_ms});
    assign b       = i_item.data_byte;

    always_comb begin
        n_count     = r_count;
        n_cr        = r_cr;
        n_too_long  = r_too_long;
        n_last      = r_last;
        n_phase     = r_phase;
        n_nc        = r_nc;
        n_alen      = r_alen;
        n_aoff      = r_aoff;
        do_append   = 1'b0;
        o_res_valid = 1'b0;
        o_res       = '0;
        if (i_accept) begin
            if (expired) begin
                n_count = '0; n_cr = 1'b0; n_too_long = 1'b0;
                n_phase = acp_pkg::PH_A; n_nc = '0; n_alen = '0; n_aoff = '0;
            end
            if (i_item.opcode == acp_pkg::OP_BYTE) begin
                n_last = i_item.now_ms;
                if (n_cr) begin
                    n_cr = 1'b0;
                    if (b == acp_pkg::CH_LF) begin
                        // Line complete: report its classification.
                        if (n_too_long) begin
                            o_res_valid     = 1'b1;
                            o_res.verdict   = acp_pkg::VERDICT_ERROR;
                        end else if (n_count != '0) begin
                            o_res_valid     = 1'b1;
                            o_res.verdict   = acp_pkg::VERDICT_ERROR;
                            unique case (n_phase)
                                acp_pkg::PH_PLUS: begin
                                    o_res.verdict = acp_pkg::VERDICT_OK;
                                end
                                acp_pkg::PH_NAME, acp_pkg::PH_EXEC: begin
                                    if (i_handler_present) begin
                                        o_res.verdict      = acp_pkg::VERDICT_REQUEST;
                                        o_res.command_kind = acp_pkg::KIND_EXEC;
                                        o_res.name_length  = to8(n_nc);
                                    end
                                end
                                acp_pkg::PH_QUERY, acp_pkg::PH_QEND: begin
                                    if (i_handler_present) begin
                                        o_res.verdict      = acp_pkg::VERDICT_REQUEST;
                                        o_res.command_kind = acp_pkg::KIND_QUERY;
                                        o_res.name_length  = to8(n_nc);
                                    end
                                end
                                acp_pkg::PH_ARGS, acp_pkg::PH_SETUP_END: begin
                                    if (i_handler_present) begin
                                        o_res.verdict      = acp_pkg::VERDICT_REQUEST;
                                        o_res.command_kind = acp_pkg::KIND_SETUP;
                                        o_res.name_length  = to8(n_nc);
                                        o_res.args_offset  = to8(n_aoff);
                                        o_res.args_length  = to8(n_alen);
                                    end
                                end
                                default: begin
                                    o_res.verdict = acp_pkg::VERDICT_ERROR;
                                end
                            endcase
                        end
                        n_count = '0; n_too_long = 1'b0;
                        n_phase = acp_pkg::PH_A; n_nc = '0; n_alen = '0; n_aoff = '0;
                    end else begin
                        n_count = '0; n_too_long = 1'b0;
                        n_phase = acp_pkg::PH_A; n_nc = '0; n_alen = '0; n_aoff = '0;
                        if (b == acp_pkg::CH_CR) begin
                            n_cr = 1'b1;
                        end else begin
                            do_append = 1'b1;
                        end
                    end
                end else if (b == acp_pkg::CH_LF) begin
                    n_count = '0; n_too_long = 1'b0;
                    n_phase = acp_pkg::PH_A; n_nc = '0; n_alen = '0; n_aoff = '0;
                end else if (b == acp_pkg::CH_CR) begin
                    n_cr = 1'b1;
                end else begin
                    do_append = 1'b1;
                end

                if (do_append && !n_too_long) begin
                    if (n_count == LINE_MAX) begin
                        n_too_long = 1'b1;
                    end else begin
                        unique case (n_phase)
                            acp_pkg::PH_A: begin
                                n_phase = (b == acp_pkg::CH_A) ? acp_pkg::PH_T : acp_pkg::PH_ERR;
                            end
                            acp_pkg::PH_T: begin
                                n_phase = (b == acp_pkg::CH_T) ? acp_pkg::PH_PLUS
                                                               : acp_pkg::PH_ERR;
                            end
                            acp_pkg::PH_PLUS: begin
                                n_phase = (b == acp_pkg::CH_PLUS) ? acp_pkg::PH_NAME0
                                                                  : acp_pkg::PH_ERR;
                            end
                            acp_pkg::PH_NAME0: begin
                                if (acp_pkg::is_name_byte(b)) begin
                                    n_phase = acp_pkg::PH_NAME;
                                    n_nc    = CW'(1);
                                end else begin
                                    n_phase = acp_pkg::PH_ERR;
                                end
                            end
                            acp_pkg::PH_NAME: begin
                                priority if (acp_pkg::is_name_byte(b)) begin
                                    n_nc = n_nc + CW'(1);
                                end else if (b == acp_pkg::CH_NUL) begin
                                    n_phase = acp_pkg::PH_EXEC;
                                end else if (b == acp_pkg::CH_QUERY) begin
                                    n_phase = acp_pkg::PH_QUERY;
                                end else if (b == acp_pkg::CH_EQ) begin
                                    n_phase = acp_pkg::PH_ARGS;
                                    n_aoff  = n_count + CW'(1);
                                end else begin
                                    n_phase = acp_pkg::PH_ERR;
                                end
                            end
                            acp_pkg::PH_QUERY: begin
                                n_phase = (b == acp_pkg::CH_NUL) ? acp_pkg::PH_QEND
                                                                 : acp_pkg::PH_ERR;
                            end
                            acp_pkg::PH_ARGS: begin
                                if (b == acp_pkg::CH_NUL) begin
                                    n_phase = acp_pkg::PH_SETUP_END;
                                end else begin
                                    n_alen = n_alen + CW'(1);
                                end
                            end
                            default: begin
                                n_phase = n_phase;
                            end
                        endcase
                        n_count = n_count + CW'(1);
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count    <= '0;
            r_cr       <= 1'b0;
            r_too_long <= 1'b0;
            r_last     <= '0;
            r_phase    <= acp_pkg::PH_A;
            r_nc       <= '0;
            r_alen     <= '0;
            r_aoff     <= '0;
        end else begin
            r_count    <= n_count;
            r_cr       <= n_cr;
            r_too_long <= n_too_long;
            r_last     <= n_last;
            r_phase    <= n_phase;
            r_nc       <= n_nc;
            r_alen     <= n_alen;
            r_aoff     <= n_aoff;
        end
    end

    // A result only ever comes from a line feed that completes a CR LF pair.
    a_res_on_lf: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid |-> (i_accept && i_item.opcode == acp_pkg::OP_BYTE &&
                         i_item.data_byte == acp_pkg::CH_LF && r_cr))
        else $error("result without a completed CR LF");

    // Overflow is only flagged once the line is full.
    a_overflow_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_too_long |-> (r_count == LINE_MAX))
        else $error("overflow flagged on a line that is not full");

endmodule

// ===== rtl/acp_out_buf.sv =====
// ----------------------------------------------------------------------------
// AT command result buffer
// Output register with one skid entry behind it.
// ----------------------------------------------------------------------------
module acp_out_buf (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  acp_pkg::t_out_item i_item,
    output logic               o_full,
    output logic               o_valid,
    output acp_pkg::t_out_item o_item,
    input  logic               i_stall
);

    logic               r_out_valid, n_out_valid;
    logic               r_skid_valid, n_skid_valid;
    acp_pkg::t_out_item r_out, n_out;
    acp_pkg::t_out_item r_skid, n_skid;
    logic               take;

    assign take    = r_out_valid && !i_stall;
    assign o_full  = r_skid_valid;
    assign o_valid = r_out_valid;
    assign o_item  = r_out;

    always_comb begin
        n_out_valid  = r_out_valid;
        n_skid_valid = r_skid_valid;
        n_out        = r_out;
        n_skid       = r_skid;
        if (r_skid_valid) begin
            if (take) begin
                n_out        = r_skid;
                n_skid_valid = 1'b0;
            end
        end else if (i_push) begin
            if (!r_out_valid || take) begin
                n_out       = i_item;
                n_out_valid = 1'b1;
            end else begin
                n_skid       = i_item;
                n_skid_valid = 1'b1;
            end
        end else if (take) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out  <= n_out;
        r_skid <= n_skid;
    end

    // The skid entry is only ever occupied behind a full output register.
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid entry holds a result while the output is empty");

    // The skid entry fills only when the output was held back.
    a_skid_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!r_skid_valid && n_skid_valid) |-> (r_out_valid && i_stall && i_push))
        else $error("skid entry filled without a stalled output");

endmodule

// ===== rtl/at_command_line_parser_top.sv =====
// ----------------------------------------------------------------------------
// AT command line parser
// Builds command lines from serial bytes and classifies each CR LF line.
// ----------------------------------------------------------------------------
// The block accepts one request per clock while the skid entry is free, byte or
// time check alike, and updates the line state in that same cycle; a completed
// CR LF line, classified as its bytes arrive, puts its result into the output
// register, or into the skid entry while the output is held back. A two-entry
// output stage (output register plus one skid entry) lets input requests keep
// flowing while a result waits; the input stalls only while that skid entry is
// occupied. The bytes of the line are not kept: the running classification,
// name length, argument offset and argument length carry everything a result
// needs. A zero byte ends parsing of the line, a lone LF discards the line,
// a CR not followed by LF drops it, and more than BUFFER_BYTES-1 bytes mark it
// as overflowed. When timeout_ms is non-zero, a partial line older than the
// timeout is discarded before the request is handled. No clearing pass is
// needed after reset. Configuration registers are written through a plain
// write port; writes to an unknown index are ignored.
// ----------------------------------------------------------------------------
module at_command_line_parser_top #(
    parameter int unsigned BUFFER_BYTES = 256
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // Input request channel.
    input  logic                                i_in_valid,
    input  acp_pkg::t_in_item                   i_in_data,
    output logic                                o_in_stall,
    // Result request channel.
    output logic                                o_out_valid,
    output acp_pkg::t_out_item                  o_out_data,
    input  logic                                i_out_stall,
    // Configuration write port.
    input  logic                                i_cfg_we,
    input  logic [acp_pkg::CFG_INDEX_W-1:0]     i_cfg_index,
    input  logic [acp_pkg::CFG_DATA_W-1:0]      i_cfg_data
);

    logic               r_timeout_ms_q;
    logic [15:0]        r_timeout_ms;
    logic               r_handler_present;
    logic               accept;
    logic               res_valid;
    acp_pkg::t_out_item res;

    // The input is taken whenever the skid entry is free.
    assign accept = i_in_valid && !o_in_stall;

    // Configuration registers. Only the two defined indexes have any effect.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout_ms      <= 16'd0;
            r_handler_present <= 1'b1;
        end else if (i_cfg_we) begin
            if (i_cfg_index == acp_pkg::CFG_TIMEOUT) begin
                r_timeout_ms <= i_cfg_data;
            end else if (i_cfg_index == acp_pkg::CFG_HANDLER) begin
                r_handler_present <= i_cfg_data[0];
            end
        end
    end

    // Remembers whether any timeout is in force, purely for the check below.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout_ms_q <= 1'b0;
        end else begin
            r_timeout_ms_q <= (r_timeout_ms != 16'd0);
        end
    end

    acp_line_tracker #(
        .BUFFER_BYTES (BUFFER_BYTES)
    ) u_tracker (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_accept          (accept),
        .i_item            (i_in_data),
        .i_timeout_ms      (r_timeout_ms),
        .i_handler_present (r_handler_present),
        .o_res_valid       (res_valid),
        .o_res             (res)
    );

    acp_out_buf u_out_buf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_valid),
        .i_item  (res),
        .o_full  (o_in_stall),
        .o_valid (o_out_valid),
        .o_item  (o_out_data),
        .i_stall (i_out_stall)
    );

    // A probe or error result never carries command details.
    a_plain_verdict: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.verdict != acp_pkg::VERDICT_REQUEST) |->
        (o_out_data.command_kind == acp_pkg::KIND_EXEC &&
         o_out_data.name_length == 8'd0 && o_out_data.args_length == 8'd0 &&
         o_out_data.args_offset == 8'd0))
        else $error("non-request result carries command details");

    // The timeout flag tracks the register in the following cycle.
    a_timeout_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> (r_timeout_ms_q == ($past(r_timeout_ms) != 16'd0)))
        else $error("timeout flag out of step with its register");

endmodule
